### src/fsb_pkg.sv
// Shared constants, codes and request types for the feathered seam blend unit.
// No dependencies; the design files refer to it by scoped names, the bench files import it.
package fsb_pkg;

    // Field and datapath widths
    localparam int DIM_BITS      = 12;
    localparam int ALPHA_BITS    = 16;
    localparam int PIX_BITS      = 8;
    localparam int FEATHER_BITS  = 8;
    localparam int STATUS_BITS   = 2;
    localparam int CHANNELS      = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = DIM_BITS;
    // Strip width S1 + right_width/2 + feather needs one bit over a dimension; two are kept
    localparam int SUM_BITS      = DIM_BITS + 2;
    // Divider: quotient bits retired per pipeline stage
    localparam int DIV_STEP      = 2;
    localparam int DIV_STAGES    = (ALPHA_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int PROD_BITS     = PIX_BITS + ALPHA_BITS + 1;

    // Channel order inside a pixel
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Alpha of one in Q1.ALPHA_BITS
    localparam logic [ALPHA_BITS:0] ALPHA_ONE = {1'b1, {ALPHA_BITS{1'b0}}};

    // Register reset values
    localparam logic [DIM_BITS-1:0]     RST_WARPED_WIDTH    = DIM_BITS'(1280);
    localparam logic [DIM_BITS-1:0]     RST_WARPED_HEIGHT   = DIM_BITS'(720);
    localparam logic [DIM_BITS-1:0]     RST_LEFT_WIDTH      = DIM_BITS'(1280);
    localparam logic [DIM_BITS-1:0]     RST_RIGHT_BEGIN_ROW = DIM_BITS'(0);
    localparam logic [DIM_BITS-1:0]     RST_RIGHT_WIDTH     = DIM_BITS'(1280);
    localparam logic [DIM_BITS-1:0]     RST_RIGHT_HEIGHT    = DIM_BITS'(720);
    localparam logic [FEATHER_BITS-1:0] RST_FEATHER         = FEATHER_BITS'(10);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WARPED_WIDTH,
        REG_WARPED_HEIGHT,
        REG_LEFT_WIDTH,
        REG_RIGHT_BEGIN_ROW,
        REG_RIGHT_WIDTH,
        REG_RIGHT_HEIGHT,
        REG_FEATHER
    } cfg_reg_t;

    // Result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_CFG = 2'd1,
        ST_OUTSIDE = 2'd2
    } status_t;

    // How the final pixel is chosen
    typedef enum logic [1:0] {
        MODE_BLACK,
        MODE_LEFT,
        MODE_RIGHT,
        MODE_BLEND
    } mode_t;

    typedef logic [PIX_BITS-1:0] chan_t;
    typedef chan_t [CHANNELS-1:0] rgb_t;

    // Accepted input request
    typedef struct packed {
        logic [DIM_BITS-1:0] row;
        logic [DIM_BITS-1:0] col;
        rgb_t                left;
        rgb_t                right;
    } pix_in_t;

    // Sideband that rides along the divider
    typedef struct packed {
        mode_t   mode;
        status_t status;
        rgb_t    left;
        rgb_t    right;
    } side_t;

    // Divider request: alpha = (num << ALPHA_BITS) / den
    typedef struct packed {
        logic [DIM_BITS-1:0] num;
        logic [DIM_BITS-1:0] den;
        side_t               side;
    } div_req_t;

    // Mixer request
    typedef struct packed {
        logic [ALPHA_BITS-1:0] alpha;
        side_t                 side;
    } mix_req_t;

    // Finished pixel
    typedef struct packed {
        rgb_t    pix;
        status_t status;
    } result_t;

    // Configuration values precomputed off the request path
    typedef struct packed {
        logic                bad;
        logic [SUM_BITS-1:0] s1;
        logic [SUM_BITS-1:0] total_w;
        logic [DIM_BITS-1:0] total_h;
        logic [DIM_BITS-1:0] band_lo;
        logic [DIM_BITS:0]   band_hi;
        logic                d_pos;
        logic [DIM_BITS-1:0] d;
    } cfg_derived_t;

endpackage

### src/fsb_if.sv
// Valid/ready stream interfaces for the pixel input and result channels.
// Depends on fsb_pkg for field widths.
interface fsb_in_if;
    logic                          valid;
    logic                          ready;
    logic [fsb_pkg::DIM_BITS-1:0]  row;
    logic [fsb_pkg::DIM_BITS-1:0]  col;
    logic [fsb_pkg::PIX_BITS-1:0]  left_red;
    logic [fsb_pkg::PIX_BITS-1:0]  left_green;
    logic [fsb_pkg::PIX_BITS-1:0]  left_blue;
    logic [fsb_pkg::PIX_BITS-1:0]  right_red;
    logic [fsb_pkg::PIX_BITS-1:0]  right_green;
    logic [fsb_pkg::PIX_BITS-1:0]  right_blue;

    modport source (
        output valid, row, col, left_red, left_green, left_blue,
               right_red, right_green, right_blue,
        input  ready
    );
    modport sink (
        input  valid, row, col, left_red, left_green, left_blue,
               right_red, right_green, right_blue,
        output ready
    );
endinterface

interface fsb_out_if;
    logic                            valid;
    logic                            ready;
    logic [fsb_pkg::PIX_BITS-1:0]    out_red;
    logic [fsb_pkg::PIX_BITS-1:0]    out_green;
    logic [fsb_pkg::PIX_BITS-1:0]    out_blue;
    logic [fsb_pkg::STATUS_BITS-1:0] status;

    modport source (
        output valid, out_red, out_green, out_blue, status,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, status,
        output ready
    );
endinterface

### src/fsb_classify.sv
// Configuration registers and two-stage position classifier.
// Depends on fsb_pkg; feeds the alpha divider with a div_req_t request.
module fsb_classify (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [fsb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [fsb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  fsb_pkg::pix_in_t                   in_pix,
    output logic                               out_valid,
    input  logic                               out_ready,
    output fsb_pkg::div_req_t                  out_req
);

    logic [fsb_pkg::DIM_BITS-1:0]     ww_reg;
    logic [fsb_pkg::DIM_BITS-1:0]     wh_reg;
    logic [fsb_pkg::DIM_BITS-1:0]     lw_reg;
    logic [fsb_pkg::DIM_BITS-1:0]     rbr_reg;
    logic [fsb_pkg::DIM_BITS-1:0]     rw_reg;
    logic [fsb_pkg::DIM_BITS-1:0]     rh_reg;
    logic [fsb_pkg::FEATHER_BITS-1:0] feather_reg;

    fsb_pkg::cfg_derived_t cfgd_next;
    fsb_pkg::cfg_derived_t cfgd_reg;
    logic                  cfg_hold_reg;

    logic                          a_valid_reg;
    fsb_pkg::pix_in_t              a_pix_reg;
    logic                          a_outside_reg;
    logic                          a_left_reg;
    logic                          a_band_reg;
    logic [fsb_pkg::SUM_BITS-1:0]  a_c_reg;
    logic                          a_outside_next;
    logic                          a_left_next;
    logic                          a_band_next;
    logic [fsb_pkg::SUM_BITS-1:0]  a_c_next;

    logic                          b_valid_reg;
    fsb_pkg::div_req_t             b_req_reg;
    fsb_pkg::div_req_t             b_req_next;

    logic                          a_ready;
    logic                          b_ready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ww_reg      <= fsb_pkg::RST_WARPED_WIDTH;
            wh_reg      <= fsb_pkg::RST_WARPED_HEIGHT;
            lw_reg      <= fsb_pkg::RST_LEFT_WIDTH;
            rbr_reg     <= fsb_pkg::RST_RIGHT_BEGIN_ROW;
            rw_reg      <= fsb_pkg::RST_RIGHT_WIDTH;
            rh_reg      <= fsb_pkg::RST_RIGHT_HEIGHT;
            feather_reg <= fsb_pkg::RST_FEATHER;
        end
        else if (cfg_wr_en)
        begin
            unique case (fsb_pkg::cfg_reg_t'(cfg_index))
                fsb_pkg::REG_WARPED_WIDTH:    ww_reg  <= cfg_data[fsb_pkg::DIM_BITS-1:0];
                fsb_pkg::REG_WARPED_HEIGHT:   wh_reg  <= cfg_data[fsb_pkg::DIM_BITS-1:0];
                fsb_pkg::REG_LEFT_WIDTH:      lw_reg  <= cfg_data[fsb_pkg::DIM_BITS-1:0];
                fsb_pkg::REG_RIGHT_BEGIN_ROW: rbr_reg <= cfg_data[fsb_pkg::DIM_BITS-1:0];
                fsb_pkg::REG_RIGHT_WIDTH:     rw_reg  <= cfg_data[fsb_pkg::DIM_BITS-1:0];
                fsb_pkg::REG_RIGHT_HEIGHT:    rh_reg  <= cfg_data[fsb_pkg::DIM_BITS-1:0];
                fsb_pkg::REG_FEATHER:
                    feather_reg <= cfg_data[fsb_pkg::FEATHER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Hold off requests for the cycle after a write while the geometry settles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_hold_reg <= 1'b0;
        end
        else
        begin
            cfg_hold_reg <= cfg_wr_en;
        end
    end

    // Strip geometry, recomputed every cycle from the registers
    always_comb
    begin
        logic [fsb_pkg::DIM_BITS-1:0] half_w;
        half_w          = ww_reg >> 1;
        cfgd_next.bad   = lw_reg < half_w;
        cfgd_next.s1    = fsb_pkg::SUM_BITS'(lw_reg) - fsb_pkg::SUM_BITS'(half_w)
                        + fsb_pkg::SUM_BITS'(feather_reg);
        cfgd_next.total_w = cfgd_next.s1 + fsb_pkg::SUM_BITS'(rw_reg >> 1)
                          + fsb_pkg::SUM_BITS'(feather_reg);
        cfgd_next.total_h = (wh_reg > rh_reg) ? wh_reg : rh_reg;
        cfgd_next.band_lo = rbr_reg;
        cfgd_next.band_hi = (fsb_pkg::DIM_BITS+1)'(rbr_reg)
                          + (fsb_pkg::DIM_BITS+1)'(rh_reg);
        cfgd_next.d_pos   = ww_reg > lw_reg;
        cfgd_next.d       = ww_reg - lw_reg;
    end

    always_ff @(posedge clk)
    begin
        cfgd_reg <= cfgd_next;
    end

    // Handshake chain
    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready && !cfg_hold_reg;
    assign out_valid = b_valid_reg;
    assign out_req   = b_req_reg;

    // Stage A: position compares
    always_comb
    begin
        a_outside_next = (in_pix.row >= cfgd_reg.total_h)
                      || (fsb_pkg::SUM_BITS'(in_pix.col) >= cfgd_reg.total_w);
        a_left_next    = fsb_pkg::SUM_BITS'(in_pix.col) < cfgd_reg.s1;
        a_band_next    = (in_pix.row >= cfgd_reg.band_lo)
                      && ((fsb_pkg::DIM_BITS+1)'(in_pix.row) < cfgd_reg.band_hi);
        a_c_next       = fsb_pkg::SUM_BITS'(in_pix.col) - cfgd_reg.s1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid && !cfg_hold_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_pix_reg     <= in_pix;
            a_outside_reg <= a_outside_next;
            a_left_reg    <= a_left_next;
            a_band_reg    <= a_band_next;
            a_c_reg       <= a_c_next;
        end
    end

    // Stage B: pick the pixel source and status
    always_comb
    begin
        logic in_seam;
        in_seam = cfgd_reg.d_pos && (a_c_reg < fsb_pkg::SUM_BITS'(cfgd_reg.d));

        b_req_next.num        = a_c_reg[fsb_pkg::DIM_BITS-1:0];
        b_req_next.den        = cfgd_reg.d;
        b_req_next.side.left  = a_pix_reg.left;
        b_req_next.side.right = a_pix_reg.right;
        b_req_next.side.status = fsb_pkg::ST_OK;
        b_req_next.side.mode   = fsb_pkg::MODE_BLACK;

        priority if (cfgd_reg.bad)
        begin
            b_req_next.side.status = fsb_pkg::ST_BAD_CFG;
        end
        else if (a_outside_reg)
        begin
            b_req_next.side.status = fsb_pkg::ST_OUTSIDE;
        end
        else if (a_left_reg)
        begin
            b_req_next.side.mode = fsb_pkg::MODE_LEFT;
        end
        else if (!a_band_reg)
        begin
            b_req_next.side.mode = in_seam ? fsb_pkg::MODE_LEFT : fsb_pkg::MODE_BLACK;
        end
        else if (in_seam)
        begin
            // empty left red passes the right pixel
            b_req_next.side.mode = (a_pix_reg.left[fsb_pkg::CH_RED] == '0)
                                 ? fsb_pkg::MODE_RIGHT : fsb_pkg::MODE_BLEND;
        end
        else
        begin
            b_req_next.side.mode = fsb_pkg::MODE_RIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_req_reg <= b_req_next;
        end
    end

    // A blend request always has a nonzero divisor above the numerator
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && (b_req_reg.side.mode == fsb_pkg::MODE_BLEND)
        |-> (b_req_reg.den != '0) && (b_req_reg.num < b_req_reg.den)
            && (b_req_reg.side.status == fsb_pkg::ST_OK))
    else $error("blend request with unusable divisor");

    // Error status only ever comes with a black pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && (b_req_reg.side.status != fsb_pkg::ST_OK)
        |-> (b_req_reg.side.mode == fsb_pkg::MODE_BLACK))
    else $error("error status without black pixel");

endmodule

### src/fsb_divider.sv
// Pipelined restoring divider that turns c / D into a Q0.ALPHA_BITS alpha.
// Depends on fsb_pkg; DIV_STEP quotient bits per stage, sideband rides along.
module fsb_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fsb_pkg::div_req_t  in_req,
    output logic               out_valid,
    input  logic               out_ready,
    output fsb_pkg::mix_req_t  out_req
);

    localparam int LAST = fsb_pkg::DIV_STAGES - 1;

    logic [fsb_pkg::DIV_STAGES-1:0] valid_reg;
    logic [fsb_pkg::DIM_BITS-1:0]   rem_reg  [fsb_pkg::DIV_STAGES];
    logic [fsb_pkg::ALPHA_BITS-1:0] quo_reg  [fsb_pkg::DIV_STAGES];
    logic [fsb_pkg::DIM_BITS-1:0]   den_reg  [fsb_pkg::DIV_STAGES];
    fsb_pkg::side_t                 side_reg [fsb_pkg::DIV_STAGES];

    logic [fsb_pkg::DIM_BITS-1:0]   rem_next [fsb_pkg::DIV_STAGES];
    logic [fsb_pkg::ALPHA_BITS-1:0] quo_next [fsb_pkg::DIV_STAGES];

    logic [fsb_pkg::DIV_STAGES-1:0] src_valid;
    logic [fsb_pkg::DIM_BITS-1:0]   src_rem  [fsb_pkg::DIV_STAGES];
    logic [fsb_pkg::ALPHA_BITS-1:0] src_quo  [fsb_pkg::DIV_STAGES];
    logic [fsb_pkg::DIM_BITS-1:0]   src_den  [fsb_pkg::DIV_STAGES];
    fsb_pkg::side_t                 src_side [fsb_pkg::DIV_STAGES];

    logic [fsb_pkg::DIV_STAGES:0]   stage_ready;

    assign stage_ready[fsb_pkg::DIV_STAGES] = out_ready;
    assign in_ready = stage_ready[0];

    for (genvar s = 0; s < fsb_pkg::DIV_STAGES; s++)
    begin : g_stage
        // Stage input: the request port or the previous stage
        if (s == 0)
        begin : g_first
            assign src_valid[s] = in_valid;
            assign src_rem[s]   = in_req.num;
            assign src_quo[s]   = '0;
            assign src_den[s]   = in_req.den;
            assign src_side[s]  = in_req.side;
        end
        else
        begin : g_rest
            assign src_valid[s] = valid_reg[s-1];
            assign src_rem[s]   = rem_reg[s-1];
            assign src_quo[s]   = quo_reg[s-1];
            assign src_den[s]   = den_reg[s-1];
            assign src_side[s]  = side_reg[s-1];
        end

        assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];

        // Shift-compare-subtract, DIV_STEP times
        always_comb
        begin
            logic [fsb_pkg::DIM_BITS:0]     wide;
            logic [fsb_pkg::DIM_BITS-1:0]   rem;
            logic [fsb_pkg::ALPHA_BITS-1:0] quo;
            logic                           qbit;
            wide = '0;
            qbit = 1'b0;
            rem  = src_rem[s];
            quo  = src_quo[s];
            for (int k = 0; k < fsb_pkg::DIV_STEP; k++)
            begin
                if (s * fsb_pkg::DIV_STEP + k < fsb_pkg::ALPHA_BITS)
                begin
                    wide = {rem, 1'b0};
                    qbit = wide >= {1'b0, src_den[s]};
                    if (qbit)
                    begin
                        wide = wide - {1'b0, src_den[s]};
                    end
                    rem = wide[fsb_pkg::DIM_BITS-1:0];
                    quo = {quo[fsb_pkg::ALPHA_BITS-2:0], qbit};
                end
            end
            rem_next[s] = rem;
            quo_next[s] = quo;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (stage_ready[s])
            begin
                valid_reg[s] <= src_valid[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[s] && src_valid[s])
            begin
                rem_reg[s]  <= rem_next[s];
                quo_reg[s]  <= quo_next[s];
                den_reg[s]  <= src_den[s];
                side_reg[s] <= src_side[s];
            end
        end
    end

    assign out_valid     = valid_reg[LAST];
    assign out_req.alpha = quo_reg[LAST];
    assign out_req.side  = side_reg[LAST];

    // Finished blend division leaves a remainder below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && (side_reg[LAST].mode == fsb_pkg::MODE_BLEND)
        |-> (rem_reg[LAST] < den_reg[LAST]))
    else $error("divider remainder not reduced");

endmodule

### src/fsb_mixer.sv
// Two-stage alpha mixer: per-channel products, then sum and source select.
// Depends on fsb_pkg; its second stage is the block's output register.
module fsb_mixer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fsb_pkg::mix_req_t  in_req,
    output logic               out_valid,
    input  logic               out_ready,
    output fsb_pkg::result_t   out_res
);

    logic                          p_valid_reg;
    fsb_pkg::side_t                p_side_reg;
    logic [fsb_pkg::PROD_BITS-1:0] pl_reg [fsb_pkg::CHANNELS];
    logic [fsb_pkg::PROD_BITS-1:0] pr_reg [fsb_pkg::CHANNELS];
    logic [fsb_pkg::PROD_BITS-1:0] pl_next [fsb_pkg::CHANNELS];
    logic [fsb_pkg::PROD_BITS-1:0] pr_next [fsb_pkg::CHANNELS];
    logic [fsb_pkg::ALPHA_BITS:0]  one_minus_a;

    logic                          o_valid_reg;
    fsb_pkg::result_t              o_res_reg;
    fsb_pkg::result_t              o_res_next;

    logic                          p_ready;
    logic                          o_ready;

    assign o_ready   = !o_valid_reg || out_ready;
    assign p_ready   = !p_valid_reg || o_ready;
    assign in_ready  = p_ready;
    assign out_valid = o_valid_reg;
    assign out_res   = o_res_reg;

    // Stage P: weight each channel
    assign one_minus_a = fsb_pkg::ALPHA_ONE - (fsb_pkg::ALPHA_BITS+1)'(in_req.alpha);

    always_comb
    begin
        for (int ch = 0; ch < fsb_pkg::CHANNELS; ch++)
        begin
            pl_next[ch] = fsb_pkg::PROD_BITS'(in_req.side.left[ch])
                        * fsb_pkg::PROD_BITS'(one_minus_a);
            pr_next[ch] = fsb_pkg::PROD_BITS'(in_req.side.right[ch])
                        * fsb_pkg::PROD_BITS'(in_req.alpha);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (p_ready)
        begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ready && in_valid)
        begin
            p_side_reg <= in_req.side;
            for (int ch = 0; ch < fsb_pkg::CHANNELS; ch++)
            begin
                pl_reg[ch] <= pl_next[ch];
                pr_reg[ch] <= pr_next[ch];
            end
        end
    end

    // Stage O: sum, drop the fraction, select the source
    always_comb
    begin
        logic [fsb_pkg::PROD_BITS-1:0] sum;
        fsb_pkg::rgb_t                 blend;
        sum = '0;
        for (int ch = 0; ch < fsb_pkg::CHANNELS; ch++)
        begin
            sum       = pl_reg[ch] + pr_reg[ch];
            blend[ch] = sum[fsb_pkg::ALPHA_BITS +: fsb_pkg::PIX_BITS];
        end
        o_res_next.status = p_side_reg.status;
        unique case (p_side_reg.mode)
            fsb_pkg::MODE_BLACK: o_res_next.pix = '0;
            fsb_pkg::MODE_LEFT:  o_res_next.pix = p_side_reg.left;
            fsb_pkg::MODE_RIGHT: o_res_next.pix = p_side_reg.right;
            fsb_pkg::MODE_BLEND: o_res_next.pix = blend;
            default:             o_res_next.pix = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && p_valid_reg)
        begin
            o_res_reg <= o_res_next;
        end
    end

    // Any error result leaves as a black pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && (o_res_reg.status != fsb_pkg::ST_OK)
        |-> (o_res_reg.pix == '0))
    else $error("error result with non-black pixel");

endmodule

### src/feathered_seam_blend_unit.sv
// Top level of the feathered seam blend unit: classifier, divider, mixer.
// Depends on fsb_pkg, fsb_if, fsb_classify, fsb_divider and fsb_mixer.
//
// Composites one pixel of a stitched strip per request. pixel_in carries the
// output row and column with the warped-left and aligned-right pixels;
// pixel_out returns the composited pixel and a status code. Both channels
// are valid/ready: a request moves on a clock edge with valid and ready high.
// Geometry registers are written through cfg_wr_en / cfg_index / cfg_data,
// one per cycle, while no requests are in flight; indexes past the feather
// register are ignored. pixel_in.ready is low for the cycle after each write.
// Twelve register stages: two classify stages, eight divider stages (two
// quotient bits each for the 16-bit alpha) and two mixer stages.
// A result leaves from the mixer's output register. Throughput is one pixel
// per clock while pixel_out.ready is high and no write holds off requests.
// rst_n (asynchronous, active low) empties the pipeline and loads the
// default 1280x720 geometry with a feather of 10.
// When the receiver stalls, each stage holds its request; empty stages
// upstream keep filling, so pixel_in.ready stays high until the pipe is full.
module feathered_seam_blend_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [fsb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [fsb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    fsb_in_if.sink                             pixel_in,
    fsb_out_if.source                          pixel_out
);

    fsb_pkg::pix_in_t  in_pix;
    fsb_pkg::div_req_t div_req;
    fsb_pkg::mix_req_t mix_req;
    fsb_pkg::result_t  res;
    logic              div_valid;
    logic              div_ready;
    logic              mix_valid;
    logic              mix_ready;

    // Pack the input request
    always_comb
    begin
        in_pix.row                    = pixel_in.row;
        in_pix.col                    = pixel_in.col;
        in_pix.left[fsb_pkg::CH_RED]    = pixel_in.left_red;
        in_pix.left[fsb_pkg::CH_GREEN]  = pixel_in.left_green;
        in_pix.left[fsb_pkg::CH_BLUE]   = pixel_in.left_blue;
        in_pix.right[fsb_pkg::CH_RED]   = pixel_in.right_red;
        in_pix.right[fsb_pkg::CH_GREEN] = pixel_in.right_green;
        in_pix.right[fsb_pkg::CH_BLUE]  = pixel_in.right_blue;
    end

    fsb_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (pixel_in.valid),
        .in_ready  (pixel_in.ready),
        .in_pix    (in_pix),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_req   (div_req)
    );

    fsb_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_req    (div_req),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .out_req   (mix_req)
    );

    fsb_mixer u_mixer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .in_req    (mix_req),
        .out_valid (pixel_out.valid),
        .out_ready (pixel_out.ready),
        .out_res   (res)
    );

    // Unpack the result
    assign pixel_out.out_red   = res.pix[fsb_pkg::CH_RED];
    assign pixel_out.out_green = res.pix[fsb_pkg::CH_GREEN];
    assign pixel_out.out_blue  = res.pix[fsb_pkg::CH_BLUE];
    assign pixel_out.status    = res.status;

endmodule

### bench/fsb_blend_check.sv
`timescale 1ns / 100ps
// Result checker for feathered_seam_blend_unit: tracks the geometry registers,
// predicts the composited pixel of every accepted request, compares results.
// Depends on fsb_pkg and the fsb_in_if / fsb_out_if stream interfaces.
module fsb_blend_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [fsb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [fsb_pkg::CFG_DATA_BITS-1:0] cfg_data,
    fsb_in_if                                 pixel_in,
    fsb_out_if                                pixel_out,
    output int                                mismatches,
    output int                                pending
);
    import fsb_pkg::*;

    localparam int REPORT_LIMIT = 10;
    localparam int PIX_MAX      = (1 << PIX_BITS) - 1;

    // Local copy of the geometry registers
    logic [DIM_BITS-1:0]     warped_width;
    logic [DIM_BITS-1:0]     warped_height;
    logic [DIM_BITS-1:0]     left_width;
    logic [DIM_BITS-1:0]     right_begin_row;
    logic [DIM_BITS-1:0]     right_width;
    logic [DIM_BITS-1:0]     right_height;
    logic [FEATHER_BITS-1:0] feather;

    // Composited pixels still owed by the unit, oldest first
    result_t expected_pixels[$];

    // One channel of the linear feather, alpha in Q0.ALPHA_BITS
    function automatic chan_t feather_channel(input int l, input int r, input longint alpha);
        longint v;
        v = (longint'(l) * ((longint'(1) << ALPHA_BITS) - alpha) + longint'(r) * alpha)
            >>> ALPHA_BITS;
        return chan_t'((v > PIX_MAX) ? PIX_MAX : v);
    endfunction

    // Expected pixel and status for one position under the current geometry
    function automatic result_t composite_pixel(input int row, input int col,
                                                input rgb_t lft, input rgb_t rgt);
        int      ww, wh, lw, rw, rh, half_w, s1, total_w, total_h;
        int      c, seam, band_lo, band_hi;
        longint  alpha;
        result_t res;
        ww      = int'(warped_width);
        wh      = int'(warped_height);
        lw      = int'(left_width);
        rw      = int'(right_width);
        rh      = int'(right_height);
        half_w  = ww / 2;
        res.pix = '0;
        res.status = ST_OK;
        if (lw < half_w) begin
            res.status = ST_BAD_CFG;
        end
        else begin
            s1      = lw - half_w + int'(feather);
            total_w = s1 + rw / 2 + int'(feather);
            total_h = (wh > rh) ? wh : rh;
            if (row >= total_h || col >= total_w) begin
                res.status = ST_OUTSIDE;
            end
            else if (col < s1) begin
                res.pix = lft;
            end
            else begin
                c       = col - s1;
                seam    = ww - lw;
                band_lo = int'(right_begin_row);
                band_hi = band_lo + rh;
                if (row < band_lo || row >= band_hi) begin
                    // Above or below the right image: left inside the seam, else black
                    if (c < seam)
                        res.pix = lft;
                end
                else if (c < seam) begin
                    if (lft[CH_RED] == '0) begin
                        res.pix = rgt;
                    end
                    else begin
                        alpha = (longint'(c) << ALPHA_BITS) / seam;
                        for (int ch = 0; ch < CHANNELS; ch++)
                            res.pix[ch] = feather_channel(int'(lft[ch]), int'(rgt[ch]),
                                                          alpha);
                    end
                end
                else begin
                    res.pix = rgt;
                end
            end
        end
        return res;
    endfunction

    // Register writes, predictions on accept, comparisons on result
    always @(posedge clk or negedge rst_n)
    begin : track
        result_t want;
        result_t got;
        rgb_t    lft;
        rgb_t    rgt;
        if (!rst_n)
        begin
            warped_width    = RST_WARPED_WIDTH;
            warped_height   = RST_WARPED_HEIGHT;
            left_width      = RST_LEFT_WIDTH;
            right_begin_row = RST_RIGHT_BEGIN_ROW;
            right_width     = RST_RIGHT_WIDTH;
            right_height    = RST_RIGHT_HEIGHT;
            feather         = RST_FEATHER;
            expected_pixels.delete();
            mismatches      = 0;
            pending         = 0;
        end
        else
        begin
            // Result side first: nothing leaves in the cycle it entered
            if (pixel_out.valid && pixel_out.ready)
            begin
                got.pix[CH_RED]   = pixel_out.out_red;
                got.pix[CH_GREEN] = pixel_out.out_green;
                got.pix[CH_BLUE]  = pixel_out.out_blue;
                got.status        = status_t'(pixel_out.status);
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected pixel rgb %0d/%0d/%0d status %0d", $time,
                                 got.pix[CH_RED], got.pix[CH_GREEN], got.pix[CH_BLUE],
                                 got.status);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.pix[CH_RED] !== want.pix[CH_RED]
                        || got.pix[CH_GREEN] !== want.pix[CH_GREEN]
                        || got.pix[CH_BLUE] !== want.pix[CH_BLUE]
                        || got.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: mismatch exp %0d/%0d/%0d st %0d got %0d/%0d/%0d st %0d",
                                     $time, want.pix[CH_RED], want.pix[CH_GREEN],
                                     want.pix[CH_BLUE], want.status, got.pix[CH_RED],
                                     got.pix[CH_GREEN], got.pix[CH_BLUE], got.status);
                    end
                end
            end

            // Request side
            if (pixel_in.valid && pixel_in.ready)
            begin
                lft[CH_RED]   = pixel_in.left_red;
                lft[CH_GREEN] = pixel_in.left_green;
                lft[CH_BLUE]  = pixel_in.left_blue;
                rgt[CH_RED]   = pixel_in.right_red;
                rgt[CH_GREEN] = pixel_in.right_green;
                rgt[CH_BLUE]  = pixel_in.right_blue;
                want = composite_pixel(int'(pixel_in.row), int'(pixel_in.col), lft, rgt);
                expected_pixels.insert(expected_pixels.size(), want);
            end

            // Geometry writes take effect for later requests
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_WARPED_WIDTH:    warped_width    = cfg_data;
                    REG_WARPED_HEIGHT:   warped_height   = cfg_data;
                    REG_LEFT_WIDTH:      left_width      = cfg_data;
                    REG_RIGHT_BEGIN_ROW: right_begin_row = cfg_data;
                    REG_RIGHT_WIDTH:     right_width     = cfg_data;
                    REG_RIGHT_HEIGHT:    right_height    = cfg_data;
                    REG_FEATHER:         feather         = cfg_data[FEATHER_BITS-1:0];
                    default: ;
                endcase
            end

            pending = expected_pixels.size();
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Testbench top for feathered_seam_blend_unit: clock, reset, geometry writes,
// pixel requests and result back-pressure; fsb_blend_check does the checking.
// Depends on fsb_pkg, fsb_if, feathered_seam_blend_unit and fsb_blend_check.
module tb;
    import fsb_pkg::*;

    localparam int CLK_HALF_NS      = 2;
    localparam int RESET_CYCLES     = 10;
    localparam int SETTLE_CYCLES    = 20;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int TIMEOUT_NS       = 4_000_000;
    localparam int DIM_MAX          = (1 << DIM_BITS) - 1;
    // Index past the feather register; the unit ignores writes to it
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = CFG_IDX_BITS'(7);

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int                       mismatches;
    int                       pending_pixels;

    // Pacing shared by the request and result sides
    bit steady_mode;
    bit gaps_off;
    int long_holds_wanted;
    int long_holds_done;

    // Geometry the random positions aim at
    bit aim_bad;
    int aim_s1, aim_seam, aim_total_w, aim_total_h, aim_band_lo, aim_band_hi;

    fsb_in_if  pixel_in_ch ();
    fsb_out_if pixel_out_ch ();

    feathered_seam_blend_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (pixel_in_ch),
        .pixel_out (pixel_out_ch)
    );

    fsb_blend_check blend_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_in   (pixel_in_ch),
        .pixel_out  (pixel_out_ch),
        .mismatches (mismatches),
        .pending    (pending_pixels)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb NOT OK");
        $finish;
    end

    function automatic int clamp_dim(input int v);
        return (v < 0) ? 0 : ((v > DIM_MAX) ? DIM_MAX : v);
    endfunction

    // Mostly random, with the channel extremes favored
    function automatic chan_t random_chan();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        else if (roll < 20)
            return '1;
        return chan_t'($urandom_range(0, 255));
    endfunction

    // Sender idle cycles after a request: mostly none or short, a few long
    function automatic int idle_gap();
        int roll;
        if (steady_mode || gaps_off)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void aim_geometry(input int ww, input int wh, input int lw,
                                         input int rbr, input int rw, input int rh,
                                         input int fw);
        aim_bad     = lw < ww / 2;
        aim_s1      = lw - ww / 2 + fw;
        aim_seam    = ww - lw;
        aim_total_w = aim_s1 + rw / 2 + fw;
        aim_total_h = (wh > rh) ? wh : rh;
        aim_band_lo = rbr;
        aim_band_hi = rbr + rh;
    endfunction

    // Random position weighted toward the strip, the seam and the band edges
    function automatic pix_in_t random_pixel();
        pix_in_t p;
        int      th, tw, pick, lo, hi;
        th   = (aim_total_h > DIM_MAX) ? DIM_MAX + 1 : aim_total_h;
        tw   = (aim_total_w > DIM_MAX) ? DIM_MAX + 1 : aim_total_w;
        pick = $urandom_range(0, 99);
        if (aim_bad || th <= 0 || tw <= 0 || pick >= 85)
        begin
            p.row = DIM_BITS'($urandom);
            p.col = DIM_BITS'($urandom);
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       p.row = DIM_BITS'(clamp_dim(aim_band_lo - 1));
                    1:       p.row = DIM_BITS'(clamp_dim(aim_band_lo));
                    2:       p.row = DIM_BITS'(clamp_dim(aim_band_hi - 1));
                    default: p.row = DIM_BITS'(clamp_dim(aim_band_hi));
                endcase
            end
            else
            begin
                p.row = DIM_BITS'($urandom_range(0, th - 1));
            end
            if (pick < 45)
            begin
                lo    = clamp_dim(aim_s1 - 3);
                hi    = clamp_dim(aim_s1 + ((aim_seam > 0) ? aim_seam : 0) + 3);
                p.col = DIM_BITS'($urandom_range(lo, hi));
            end
            else
            begin
                p.col = DIM_BITS'($urandom_range(0, tw - 1));
            end
        end
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            p.left[ch]  = random_chan();
            p.right[ch] = random_chan();
        end
        // Empty left red switches the blend to a right pass-through
        if ($urandom_range(0, 6) == 0)
            p.left[CH_RED] = '0;
        return p;
    endfunction

    // Offer one request from a falling edge; returns on a falling edge
    task automatic send_pixel(input pix_in_t p);
        int gap;
        pixel_in_ch.valid       = 1'b1;
        pixel_in_ch.row         = p.row;
        pixel_in_ch.col         = p.col;
        pixel_in_ch.left_red    = p.left[CH_RED];
        pixel_in_ch.left_green  = p.left[CH_GREEN];
        pixel_in_ch.left_blue   = p.left[CH_BLUE];
        pixel_in_ch.right_red   = p.right[CH_RED];
        pixel_in_ch.right_green = p.right[CH_GREEN];
        pixel_in_ch.right_blue  = p.right[CH_BLUE];
        do
            @(posedge clk);
        while (!pixel_in_ch.ready);
        @(negedge clk);
        gap = idle_gap();
        if (gap > 0)
        begin
            pixel_in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_direct(input int row, input int col,
                               input int lr, input int lg, input int lb,
                               input int rr, input int rg, input int rb);
        pix_in_t p;
        p.row             = DIM_BITS'(row);
        p.col             = DIM_BITS'(col);
        p.left[CH_RED]    = chan_t'(lr);
        p.left[CH_GREEN]  = chan_t'(lg);
        p.left[CH_BLUE]   = chan_t'(lb);
        p.right[CH_RED]   = chan_t'(rr);
        p.right[CH_GREEN] = chan_t'(rg);
        p.right[CH_BLUE]  = chan_t'(rb);
        send_pixel(p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_BITS'(value);
        @(negedge clk);
    endtask

    // Full geometry update while idle; feather carries junk in its upper bits
    task automatic write_geometry(input int ww, input int wh, input int lw, input int rbr,
                                  input int rw, input int rh, input int fw);
        write_reg(REG_WARPED_WIDTH, ww);
        write_reg(REG_WARPED_HEIGHT, wh);
        write_reg(REG_LEFT_WIDTH, lw);
        write_reg(REG_RIGHT_BEGIN_ROW, rbr);
        write_reg(REG_RIGHT_WIDTH, rw);
        write_reg(REG_RIGHT_HEIGHT, rh);
        write_reg(REG_FEATHER, ($urandom_range(0, 15) << FEATHER_BITS) | fw);
        write_reg(REG_SPARE, $urandom);
        cfg_wr_en = 1'b0;
        aim_geometry(ww, wh, lw, rbr, rw, rh, fw);
    endtask

    task automatic random_geometry();
        int ww, lw;
        ww = $urandom_range(1, DIM_MAX);
        if ($urandom_range(0, 9) == 0)
            lw = $urandom_range(0, DIM_MAX);
        else
            lw = $urandom_range(ww / 2, (ww + 200 > DIM_MAX) ? DIM_MAX : ww + 200);
        write_geometry(ww, $urandom_range(1, DIM_MAX), lw, $urandom_range(0, 2000),
                       $urandom_range(1, DIM_MAX), $urandom_range(1, DIM_MAX),
                       $urandom_range(0, 255));
    endtask

    // Stop offering until every owed pixel has come back
    task automatic wait_results_done();
        pixel_in_ch.valid = 1'b0;
        do
            @(negedge clk);
        while (pending_pixels != 0);
    endtask

    task automatic end_phase();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random requests; with_pressure adds a long result stall and a full drain
    task automatic run_random(input int count, input bit with_pressure);
        for (int i = 0; i < count; i++)
        begin
            if (with_pressure && i == 30)
            begin
                long_holds_wanted++;
                gaps_off = 1'b1;
            end
            if (with_pressure && i == 70)
                gaps_off = 1'b0;
            if (with_pressure && i == 100)
                wait_results_done();
            send_pixel(random_pixel());
        end
    endtask

    // Result side: random stalls, steady stretches and the requested long hold
    initial
    begin : result_sink
        int stall_left;
        stall_left         = 0;
        long_holds_done    = 0;
        pixel_out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_holds_done != long_holds_wanted)
            begin
                long_holds_done++;
                pixel_out_ch.ready = 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (steady_mode)
            begin
                stall_left         = 0;
                pixel_out_ch.ready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pixel_out_ch.ready = 1'b0;
            end
            else if ($urandom_range(0, 99) < 25)
            begin
                stall_left         = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                                 : $urandom_range(0, 2);
                pixel_out_ch.ready = 1'b0;
            end
            else
            begin
                pixel_out_ch.ready = 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        rst_n                   = 1'b0;
        cfg_wr_en               = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        steady_mode             = 1'b0;
        gaps_off                = 1'b0;
        long_holds_wanted       = 0;
        pixel_in_ch.valid       = 1'b0;
        pixel_in_ch.row         = '0;
        pixel_in_ch.col         = '0;
        pixel_in_ch.left_red    = '0;
        pixel_in_ch.left_green  = '0;
        pixel_in_ch.left_blue   = '0;
        pixel_in_ch.right_red   = '0;
        pixel_in_ch.right_green = '0;
        pixel_in_ch.right_blue  = '0;
        aim_geometry(RST_WARPED_WIDTH, RST_WARPED_HEIGHT, RST_LEFT_WIDTH,
                     RST_RIGHT_BEGIN_ROW, RST_RIGHT_WIDTH, RST_RIGHT_HEIGHT, RST_FEATHER);
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset geometry: no seam, left copy up to column 649, right beyond
        send_direct(0, 0, 255, 255, 255, 0, 0, 0);
        send_direct(719, 1299, 0, 0, 0, 255, 255, 255);
        send_direct(720, 0, 1, 2, 3, 4, 5, 6);
        send_direct(0, 1300, 1, 2, 3, 4, 5, 6);
        send_direct(4095, 4095, 255, 255, 255, 255, 255, 255);
        send_direct(0, 649, 17, 34, 51, 68, 85, 102);
        send_direct(0, 650, 17, 34, 51, 68, 85, 102);
        run_random(100, 1'b0);
        end_phase();

        // Small strip with a 50-column seam and the right band on rows 20..79
        write_geometry(200, 100, 150, 20, 180, 60, 5);
        send_direct(30, 54, 200, 100, 50, 10, 20, 30);
        send_direct(30, 55, 200, 100, 50, 10, 20, 30);
        send_direct(30, 104, 255, 255, 255, 0, 0, 0);
        send_direct(79, 80, 0, 100, 50, 10, 20, 30);
        send_direct(10, 60, 200, 100, 50, 10, 20, 30);
        send_direct(10, 110, 200, 100, 50, 10, 20, 30);
        send_direct(50, 110, 200, 100, 50, 10, 20, 30);
        send_direct(80, 60, 200, 100, 50, 10, 20, 30);
        send_direct(99, 149, 200, 100, 50, 10, 20, 30);
        run_random(150, 1'b1);
        end_phase();

        // Every register at its top value
        write_geometry(DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, 255);
        run_random(120, 1'b0);
        end_phase();

        // Left width, begin row and feather at zero, the rest at one: the strip is empty
        write_geometry(1, 1, 0, 0, 1, 1, 0);
        send_direct(0, 0, 9, 9, 9, 7, 7, 7);
        run_random(60, 1'b0);
        end_phase();

        // Left part one column short of half the warped width, no idling
        steady_mode = 1'b1;
        write_geometry(DIM_MAX, 300, 2046, 0, 400, 300, 12);
        send_direct(0, 0, 255, 255, 255, 255, 255, 255);
        send_direct(4095, 4095, 255, 255, 255, 255, 255, 255);
        run_random(60, 1'b0);
        end_phase();
        steady_mode = 1'b0;

        // Wide seam, band from row 500 running past the bottom of a tall strip
        write_geometry(4000, 1000, 2100, 500, 3000, 2000, 200);
        run_random(200, 1'b0);
        end_phase();

        // One-column seam, no idling
        steady_mode = 1'b1;
        write_geometry(101, 50, 100, 10, 40, 30, 3);
        run_random(120, 1'b0);
        end_phase();
        steady_mode = 1'b0;

        write_geometry(3000, 800, 1499, 100, 900, 600, 40);
        run_random(60, 1'b0);
        end_phase();

        for (int g = 0; g < 4; g++)
        begin
            random_geometry();
            run_random(150, 1'b0);
            end_phase();
        end

        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
